// ===== design/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg
// shared types and constants for the sorted list insert/delete block
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 8;
    localparam int STAT_W   = 3;
    localparam int OUTCNT_W = 5;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic [VAL_W-1:0] key;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/sli_cell.sv =====
// ----------------------------------------------------------------------------
// sli_cell
// one slot of the sorted list, shifts toward its neighbors on insert/delete
// ----------------------------------------------------------------------------
`default_nettype none

module sli_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sli_pkg::cmd_t   cmd,
    input  wire sli_pkg::entry_t prev_entry,
    input  wire logic            prev_ge,
    input  wire sli_pkg::entry_t next_entry,
    output sli_pkg::entry_t      entry,
    output logic                 ge,
    output logic                 eq
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [sli_pkg::VAL_W-1:0]    data_reg;
    logic [sli_pkg::VAL_W-1:0]    data_next;

    // slot is free or holds a value not smaller than the key
    assign ge = !valid_reg || (data_reg >= cmd.key);
    assign eq = valid_reg && (data_reg == cmd.key);

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.ins_en)
        begin
            if (prev_ge)
            begin
                valid_next = prev_entry.valid;
                data_next  = prev_entry.data;
            end
            else if (ge)
            begin
                valid_next = 1'b1;
                data_next  = cmd.key;
            end
        end
        else if (cmd.del_en && ge)
        begin
            valid_next = next_entry.valid;
            data_next  = next_entry.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== design/sorted_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// ascending list of bytes kept in a row of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken on a clock edge with start high and busy low;
//   busy stays low, so a new transaction can be given every cycle.
//   operation selects insert (value placed ahead of the first entry not
//   smaller than it) or delete (first entry equal to value is removed).
//   every transaction gives one result: done is high for one cycle, the
//   cycle after the accepting edge, with status and entry_count (count of
//   entries after the transaction, low 5 bits).
//   throughput 1 transaction per cycle: all cells compare against the
//   value at once and shift one slot toward a neighbor in the same edge.
//   insert on a full list reports full, delete on an empty list reports
//   empty, delete with no equal entry reports not found; the list is left
//   unchanged in those cases.
//   reset empties the list at once; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           operation,
    input  wire logic [sli_pkg::VAL_W-1:0]      value,
    output logic                                done,
    output logic [sli_pkg::STAT_W-1:0]          status,
    output logic [sli_pkg::OUTCNT_W-1:0]        entry_count
);

    localparam int N = sli_pkg::CAPACITY;

    sli_pkg::cmd_t                  cmd;
    sli_pkg::entry_t                entries [N];
    sli_pkg::entry_t                empty_entry;
    logic [N-1:0]                   ge_vec;
    logic [N-1:0]                   eq_vec;
    logic                           found;
    logic                           is_full;
    logic                           is_empty;

    logic [sli_pkg::CNT_W-1:0]      count_reg;
    logic [sli_pkg::CNT_W-1:0]      count_next;
    logic                           done_reg;
    logic                           done_next;
    sli_pkg::status_t               status_reg;
    sli_pkg::status_t               status_next;

    assign empty_entry.valid = 1'b0;
    assign empty_entry.data  = '0;

    assign found    = |eq_vec;
    assign is_full  = (count_reg == sli_pkg::CNT_W'(N));
    assign is_empty = (count_reg == '0);

    assign cmd.key    = value;
    assign cmd.ins_en = start && (sli_pkg::op_t'(operation) == sli_pkg::OP_INSERT) && !is_full;
    assign cmd.del_en = start && (sli_pkg::op_t'(operation) == sli_pkg::OP_DELETE) && found;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            sli_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_entry ((i == 0) ? empty_entry : entries[(i == 0) ? 0 : i - 1]),
                .prev_ge    ((i == 0) ? 1'b0 : ge_vec[(i == 0) ? 0 : i - 1]),
                .next_entry ((i == N - 1) ? empty_entry : entries[(i == N - 1) ? i : i + 1]),
                .entry      (entries[i]),
                .ge         (ge_vec[i]),
                .eq         (eq_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        done_next   = start;
        status_next = status_reg;
        if (start)
        begin
            case (sli_pkg::op_t'(operation))
                sli_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = sli_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = sli_pkg::ST_INSERTED;
                        count_next  = count_reg + 1'b1;
                    end
                end
                sli_pkg::OP_DELETE:
                begin
                    if (is_empty)
                    begin
                        status_next = sli_pkg::ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        status_next = sli_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        status_next = sli_pkg::ST_DELETED;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = sli_pkg::OUTCNT_W'(count_reg);

endmodule

`default_nettype wire
